@@ design/cau_pkg.sv @@
// Shared types and constants of the complex arithmetic unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none
package cau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Remainder width of the divider: 64-bit divisor shifted by up to 32 places
  localparam int REM_W = 96;
  localparam int QUO_W = 32;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
    logic               overflow;
  } out_t;

  // Classified beat passed from front to back
  typedef struct packed {
    logic [1:0]         cmd;
    logic               dz;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } item_t;

endpackage
`default_nettype wire

@@ design/cau_front.sv @@
// Front end: takes input beats, flags divide by zero and pushes classified items.
// Depends on cau_pkg.
`default_nettype none
module cau_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  cau_pkg::in_t      operands,
  output logic              push,
  output cau_pkg::item_t    item,
  input  wire               full
);
  import cau_pkg::*;

  logic  held;
  item_t slot;

  assign push = held && !full;
  assign busy = held && full;
  assign item = slot;

  // Hold one classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && !busy) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      slot.cmd  <= operands.cmd;
      slot.dz   <= (operands.cmd == CMD_DIV) && (operands.b_re == '0) &&
                   (operands.b_im == '0);
      slot.a_re <= operands.a_re;
      slot.a_im <= operands.a_im;
      slot.b_re <= operands.b_re;
      slot.b_im <= operands.b_im;
    end
  end

endmodule
`default_nettype wire

@@ design/cau_queue.sv @@
// Short register queue between front and back ends.
// Depends on cau_pkg.
`default_nettype none
module cau_queue #(
  parameter int DEPTH = 4
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  cau_pkg::item_t    wr_item,
  output logic              full,
  output logic              pop,
  output cau_pkg::item_t    rd_item
);
  import cau_pkg::*;

  localparam int PW = $clog2(DEPTH);

  item_t         store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  // Back end never stalls: drain one beat whenever anything is held
  assign pop     = count != '0;
  assign full    = count == (PW+1)'(DEPTH);
  assign rd_item = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= wr_item;
  end

endmodule
`default_nettype wire

@@ design/cau_back.sv @@
// Back end: multiply, combine, one-bit-per-stage divide and saturation pipeline.
// Depends on cau_pkg.
`default_nettype none
module cau_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               valid,
  input  cau_pkg::item_t    item,
  output logic              done,
  output cau_pkg::out_t     result
);
  import cau_pkg::*;

  // Stage 1: products and narrow sums
  logic               v1;
  logic [1:0]         cmd1;
  logic               dz1;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, bb_r, bb_i;
  logic signed [32:0] sum_re, sum_im;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= valid;
  end

  always_ff @(posedge clk) begin
    cmd1   <= item.cmd;
    dz1    <= item.dz;
    p_rr   <= item.a_re * item.b_re;
    p_ii   <= item.a_im * item.b_im;
    p_ri   <= item.a_re * item.b_im;
    p_ir   <= item.a_im * item.b_re;
    bb_r   <= item.b_re * item.b_re;
    bb_i   <= item.b_im * item.b_im;
    if (item.cmd == CMD_SUB) begin
      sum_re <= 33'(item.a_re) - 33'(item.b_re);
      sum_im <= 33'(item.a_im) - 33'(item.b_im);
    end else begin
      sum_re <= 33'(item.a_re) + 33'(item.b_re);
      sum_im <= 33'(item.a_im) + 33'(item.b_im);
    end
  end

  // Stage 2: combine products, form divisor
  logic               v2;
  logic [1:0]         cmd2;
  logic               dz2;
  logic signed [64:0] s_re, s_im;
  logic [63:0]        den2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    cmd2 <= cmd1;
    dz2  <= dz1;
    den2 <= 64'(bb_r) + 64'(bb_i);
    case (cmd1)
      CMD_MUL: begin
        s_re <= 65'(p_rr) - 65'(p_ii);
        s_im <= 65'(p_ri) + 65'(p_ir);
      end
      CMD_DIV: begin
        s_re <= 65'(p_rr) + 65'(p_ii);
        s_im <= 65'(p_ir) - 65'(p_ri);
      end
      default: begin
        s_re <= 65'(sum_re);
        s_im <= 65'(sum_im);
      end
    endcase
  end

  // Stage 3: sign and magnitude, scale products down and dividends up for the divider
  logic              v3;
  logic              div3;
  logic              neg3_re, neg3_im;
  logic [REM_W-1:0]  rem3_re, rem3_im;
  logic [63:0]       den3;
  logic [63:0]       mag_re, mag_im;

  always_comb begin
    mag_re = s_re[64] ? 64'(-s_re) : 64'(s_re);
    mag_im = s_im[64] ? 64'(-s_im) : 64'(s_im);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    den3    <= den2;
    div3    <= (cmd2 == CMD_DIV) && !dz2;
    neg3_re <= s_re[64] && !dz2;
    neg3_im <= s_im[64] && !dz2;
    case (cmd2)
      CMD_MUL: begin
        rem3_re <= REM_W'(mag_re >> FRAC_BITS);
        rem3_im <= REM_W'(mag_im >> FRAC_BITS);
      end
      CMD_DIV: begin
        rem3_re <= dz2 ? '0 : (REM_W'(mag_re) << FRAC_BITS);
        rem3_im <= dz2 ? '0 : (REM_W'(mag_im) << FRAC_BITS);
      end
      default: begin
        rem3_re <= REM_W'(mag_re);
        rem3_im <= REM_W'(mag_im);
      end
    endcase
  end

  // Divider chain: stage 0 checks quotient range, then one quotient bit per stage
  logic             dv   [QUO_W+1];
  logic             ddiv [QUO_W+1];
  logic             dneg_re [QUO_W+1];
  logic             dneg_im [QUO_W+1];
  logic             dbig_re [QUO_W+1];
  logic             dbig_im [QUO_W+1];
  logic [REM_W-1:0] drem_re [QUO_W+1];
  logic [REM_W-1:0] drem_im [QUO_W+1];
  logic [QUO_W-1:0] dq_re   [QUO_W+1];
  logic [QUO_W-1:0] dq_im   [QUO_W+1];
  logic [63:0]      dden    [QUO_W];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v3;
  end

  always_ff @(posedge clk) begin
    ddiv[0]    <= div3;
    dneg_re[0] <= neg3_re;
    dneg_im[0] <= neg3_im;
    drem_re[0] <= rem3_re;
    drem_im[0] <= rem3_im;
    dden[0]    <= den3;
    dq_re[0]   <= '0;
    dq_im[0]   <= '0;
    dbig_re[0] <= div3 && (rem3_re >= (REM_W'(den3) << QUO_W));
    dbig_im[0] <= div3 && (rem3_im >= (REM_W'(den3) << QUO_W));
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int B = QUO_W - 1 - k;
    logic [REM_W-1:0] dsh;
    logic             ge_re, ge_im;

    assign dsh   = REM_W'(dden[k]) << B;
    assign ge_re = drem_re[k] >= dsh;
    assign ge_im = drem_im[k] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else     dv[k+1] <= dv[k];
    end

    // Subtract and set the bit only for divide beats; others ride through
    always_ff @(posedge clk) begin
      ddiv[k+1]    <= ddiv[k];
      dneg_re[k+1] <= dneg_re[k];
      dneg_im[k+1] <= dneg_im[k];
      dbig_re[k+1] <= dbig_re[k];
      dbig_im[k+1] <= dbig_im[k];
      drem_re[k+1] <= (ddiv[k] && ge_re) ? drem_re[k] - dsh : drem_re[k];
      drem_im[k+1] <= (ddiv[k] && ge_im) ? drem_im[k] - dsh : drem_im[k];
      dq_re[k+1]   <= dq_re[k] | (QUO_W'(ddiv[k] && ge_re) << B);
      dq_im[k+1]   <= dq_im[k] | (QUO_W'(ddiv[k] && ge_im) << B);
    end

    // Pass the divisor on while a later stage still needs it
    if (k < QUO_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        dden[k+1] <= dden[k];
      end
    end
  end

  // Final stage: pick magnitude and saturate to 32 bits
  logic [REM_W-1:0] fm_re, fm_im;
  logic [31:0]      pk_re, pk_im;
  logic             ov_re, ov_im;

  always_comb begin
    if (ddiv[QUO_W]) begin
      fm_re = dbig_re[QUO_W] ? (REM_W'(1) << QUO_W) : REM_W'(dq_re[QUO_W]);
      fm_im = dbig_im[QUO_W] ? (REM_W'(1) << QUO_W) : REM_W'(dq_im[QUO_W]);
    end else begin
      fm_re = drem_re[QUO_W];
      fm_im = drem_im[QUO_W];
    end
    if (dneg_re[QUO_W]) begin
      ov_re = fm_re > REM_W'(33'h080000000);
      pk_re = ov_re ? 32'h80000000 : 32'(-fm_re);
    end else begin
      ov_re = fm_re > REM_W'(33'h07fffffff);
      pk_re = ov_re ? 32'h7fffffff : 32'(fm_re);
    end
    if (dneg_im[QUO_W]) begin
      ov_im = fm_im > REM_W'(33'h080000000);
      pk_im = ov_im ? 32'h80000000 : 32'(-fm_im);
    end else begin
      ov_im = fm_im > REM_W'(33'h07fffffff);
      pk_im = ov_im ? 32'h7fffffff : 32'(fm_im);
    end
  end

  logic dz_tag [QUO_W+4];
  // Carry the divide-by-zero mark alongside the pipeline
  always_ff @(posedge clk) begin
    dz_tag[0] <= item.dz;
    for (int i = 1; i < QUO_W + 4; i++) dz_tag[i] <= dz_tag[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[QUO_W];
  end

  always_ff @(posedge clk) begin
    result.res_re   <= pk_re;
    result.res_im   <= pk_im;
    result.overflow <= ov_re || ov_im;
    result.div_zero <= dz_tag[QUO_W+3];
  end

endmodule
`default_nettype wire

@@ design/complex_arith_unit.sv @@
// Top level of the complex arithmetic unit: front end, queue and back end.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
`default_nettype none
// One complex add, subtract, multiply or divide in signed fixed point per beat.
// A beat is taken when start is high and busy is low; a new beat may follow
// every cycle. Each result appears on result for one cycle with done high
// once its beat has passed the front register, the queue, the multiply,
// combine and scale stages, a range check, one divider stage per quotient
// bit and an output register; every command takes the same path, so
// results leave in order. The receiver cannot stall, so busy only rises if
// the queue fills, which at one beat per cycle does not happen.
module complex_arith_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  cau_pkg::in_t    operands,
  output logic            done,
  output cau_pkg::out_t   result
);
  import cau_pkg::*;

  logic  push, full, pop;
  item_t fr_item, q_item;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .push     (push),
    .item     (fr_item),
    .full     (full)
  );

  cau_queue #(.DEPTH(4)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (fr_item),
    .full    (full),
    .pop     (pop),
    .rd_item (q_item)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (pop),
    .item   (q_item),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

@@ design/cau_checker.sv @@
// Port-level checks of the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg.
`default_nettype none
module cau_checker (
  input wire            clk,
  input wire            rst,
  input wire            start,
  input wire            busy,
  input cau_pkg::out_t  result,
  input wire            done
);
  import cau_pkg::*;

  // No result straight after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every accepted beat is followed by its result strobe on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##39 done)
    else $error("result missing after accepted beat");

  // Divide by zero gives zero and no overflow
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.div_zero) |->
      (result.res_re == '0 && result.res_im == '0 && !result.overflow))
    else $error("divide by zero result not clean");

  // Overflow means at least one part sits at a limit
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |->
      (result.res_re == 32'h7fffffff || result.res_re == 32'h80000000 ||
       result.res_im == 32'h7fffffff || result.res_im == 32'h80000000))
    else $error("overflow without saturated part");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);
`default_nettype wire
